// ----- hw/rtl/ctd_pkg.sv -----
// ----------------------------------------------------------------------------
// Chunked transfer decoder package
// Shared types, character codes and the hex digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package ctd_pkg;

  // Most size digits held on one size line
  localparam int unsigned SIZE_DIGITS = 8;

  localparam int unsigned DIGIT_CNT_W = 4;
  localparam int unsigned COUNT_W     = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Output tuser bit positions
  localparam int unsigned TUSER_W         = 2;
  localparam int unsigned TUSER_PAYLOAD_V = 0;
  localparam int unsigned TUSER_PROTO_ERR = 1;

  // Framing phase, one-hot
  typedef enum logic [4:0] {
    PH_SIZE     = 5'b00001,
    PH_SIZE_LF  = 5'b00010,
    PH_DATA     = 5'b00100,
    PH_TRAIL_CR = 5'b01000,
    PH_TRAIL_LF = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ASCII hex digit decode, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chunked_transfer_decoder.sv -----
// Each byte's result is registered and shown on the master side next cycle.
// Throughput: one byte per cycle unless the result side stalls; the framing
// state and 32-bit payload down-counter update in the cycle a byte is taken.
// The output register is refilled whenever its result is taken or it is empty.
// Reset (rst_ni low, asynchronous) returns to the size line start, clears the
// counters and the sticky error, and turns payload forwarding on.
// ----------------------------------------------------------------------------
// Chunked transfer decoder
// Parses chunked body framing per byte; forwards payload bytes when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_transfer_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration write: forward_payload
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_data_i,
  // Input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] payload_byte
  output logic                             m_axis_tlast,  // chunk_done
  output logic [ctd_pkg::TUSER_W-1:0]      m_axis_tuser   // [0] payload_valid,
                                                          // [1] protocol_error
);
  import ctd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [COUNT_W-1:0]     remain_q, remain_d;
  logic [DIGIT_CNT_W-1:0] digits_q, digits_d;
  logic                   err_q, err_d;
  logic                   fwd_q;
  logic                   out_valid_q;
  logic                   in_fire;
  logic                   res_valid, res_done;
  logic [7:0]             res_byte;
  logic [COUNT_W-1:0]     remain_dec;
  hex_t                   hex;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign hex           = hex_decode(s_axis_tdata);
  assign remain_dec    = remain_q - COUNT_W'(1);

  // Framing state update for the byte being taken
  always_comb begin
    phase_d   = phase_q;
    remain_d  = remain_q;
    digits_d  = digits_q;
    err_d     = err_q;
    res_valid = 1'b0;
    res_done  = 1'b0;
    res_byte  = 8'd0;
    if (in_fire && !err_q) begin
      unique case (phase_q)
        PH_SIZE: begin
          if (s_axis_tdata == CHAR_CR) begin
            if (digits_q == '0) err_d = 1'b1;
            else                phase_d = PH_SIZE_LF;
          end else if (!hex.ok || digits_q >= DIGIT_CNT_W'(SIZE_DIGITS)) begin
            err_d = 1'b1;
          end else begin
            remain_d = {remain_q[COUNT_W-5:0], hex.val};
            digits_d = digits_q + DIGIT_CNT_W'(1);
          end
        end
        PH_SIZE_LF: begin
          if (s_axis_tdata != CHAR_LF) begin
            err_d = 1'b1;
          end else begin
            digits_d = '0;
            phase_d  = (remain_q == '0) ? PH_TRAIL_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          if (fwd_q) begin
            res_valid = 1'b1;
            res_byte  = s_axis_tdata;
          end
          remain_d = remain_dec;
          if (remain_dec == '0) phase_d = PH_TRAIL_CR;
        end
        PH_TRAIL_CR: begin
          if (s_axis_tdata != CHAR_CR) err_d = 1'b1;
          else                         phase_d = PH_TRAIL_LF;
        end
        PH_TRAIL_LF: begin
          if (s_axis_tdata != CHAR_LF) begin
            err_d = 1'b1;
          end else begin
            res_done = 1'b1;
            phase_d  = PH_SIZE;
            remain_d = '0;
            digits_d = '0;
          end
        end
        default: err_d = 1'b1;
      endcase
    end
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIZE;
      remain_q    <= '0;
      digits_q    <= '0;
      err_q       <= 1'b0;
      fwd_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      digits_q <= digits_d;
      err_q    <= err_d;
      if (cfg_valid_i && cfg_ready_o) fwd_q <= cfg_data_i;
      if (in_fire)            out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Result register, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      m_axis_tdata                  <= res_byte;
      m_axis_tlast                  <= res_done;
      m_axis_tuser[TUSER_PAYLOAD_V] <= res_valid;
      m_axis_tuser[TUSER_PROTO_ERR] <= err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ctd_checker.sv -----
// ----------------------------------------------------------------------------
// Chunked transfer decoder checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [7:0]                  m_axis_tdata,
  input wire logic                        m_axis_tlast,
  input wire logic [ctd_pkg::TUSER_W-1:0] m_axis_tuser
);
  import ctd_pkg::*;

  // Once an error is shown, every later result keeps it
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[TUSER_PROTO_ERR])
      |=> (!m_axis_tvalid || m_axis_tuser[TUSER_PROTO_ERR]))
    else $error("protocol error flag dropped");

  // An errored result carries neither payload nor chunk end
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[TUSER_PROTO_ERR])
      |-> (!m_axis_tuser[TUSER_PAYLOAD_V] && !m_axis_tlast))
    else $error("payload or chunk end alongside error");

  // Payload byte and trailer end never share a result
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[TUSER_PAYLOAD_V] && m_axis_tlast))
    else $error("payload and chunk end together");

  // Non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[TUSER_PAYLOAD_V]) |-> (m_axis_tdata == 8'd0))
    else $error("stray payload byte");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
